// ===== rtl/fat_pkg.sv =====
// Shared types and constants for the four-anchor trilateration core.
package fat_pkg;

    localparam int DIST_W   = 15;
    localparam int EXT_W    = 15;
    localparam int SQ_W     = 2 * DIST_W;
    localparam int NUM_W    = SQ_W + 2;
    localparam int DEN_W    = EXT_W + 1;
    localparam int RAD_W    = SQ_W;
    localparam int ROOT_W   = RAD_W / 2;
    localparam int OTH_W    = EXT_W + 2;
    localparam int SUM_W    = NUM_W + 2;
    localparam int POS_W    = 16;
    localparam int N_LANES  = 4;
    localparam int LANE_LAT = 2 + NUM_W + 2 + ROOT_W + 1;
    localparam int MRG_LAT  = 2;
    localparam int PIPE_LAT = LANE_LAT + MRG_LAT;

    localparam logic [EXT_W-1:0] EXT_RESET = EXT_W'(1000);

    typedef enum logic {
        CFG_LENGTH = 1'b0,
        CFG_WIDTH  = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [DIST_W-1:0] p;
        logic [SQ_W-1:0]   p2;
        logic              neg;
        logic              dz;
    } t_pre_side;

    typedef struct packed {
        logic signed [NUM_W-1:0] lin;
        logic                    err;
    } t_post_side;

    typedef struct packed {
        logic signed [NUM_W-1:0] lin;
        logic signed [OTH_W-1:0] oth;
        logic                    err;
    } t_lane_res;

endpackage

// ===== rtl/fat_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module fat_div #(
    parameter int SIDE_W = 1
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [fat_pkg::NUM_W-1:0]  i_num,
    input  logic [fat_pkg::DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0]          i_side,
    output logic [fat_pkg::NUM_W-1:0]  o_quo,
    output logic [SIDE_W-1:0]          o_side
);
    import fat_pkg::*;

    logic [DEN_W-1:0]  r_rem  [NUM_W];
    logic [NUM_W-1:0]  r_nq   [NUM_W];
    logic [SIDE_W-1:0] r_side [NUM_W];
    logic [DEN_W-1:0]  n_rem  [NUM_W];
    logic [NUM_W-1:0]  n_nq   [NUM_W];
    logic [DEN_W-1:0]  s_rem  [NUM_W];
    logic [NUM_W-1:0]  s_nq   [NUM_W];
    logic [SIDE_W-1:0] s_side [NUM_W];

    always_comb begin
        s_rem[0]  = '0;
        s_nq[0]   = i_num;
        s_side[0] = i_side;
        for (int k = 1; k < NUM_W; k++) begin
            s_rem[k]  = r_rem[k-1];
            s_nq[k]   = r_nq[k-1];
            s_side[k] = r_side[k-1];
        end
    end

    always_comb begin
        logic [DEN_W:0] trial;
        logic           qb;
        for (int k = 0; k < NUM_W; k++) begin
            trial = {s_rem[k], s_nq[k][NUM_W-1]};
            qb    = (trial >= {1'b0, i_den});
            n_rem[k] = qb ? DEN_W'(trial - {1'b0, i_den}) : trial[DEN_W-1:0];
            n_nq[k]  = {s_nq[k][NUM_W-2:0], qb};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NUM_W; k++) begin
                r_rem[k]  <= n_rem[k];
                r_nq[k]   <= n_nq[k];
                r_side[k] <= s_side[k];
            end
        end
    end

    assign o_quo  = r_nq[NUM_W-1];
    assign o_side = r_side[NUM_W-1];

endmodule

// ===== rtl/fat_sqrt.sv =====
// Pipelined digit-by-digit integer square root, one root bit per stage.
module fat_sqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [fat_pkg::RAD_W-1:0]   i_rad,
    input  logic [SIDE_W-1:0]           i_side,
    output logic [fat_pkg::ROOT_W-1:0]  o_root,
    output logic                        o_exact,
    output logic [SIDE_W-1:0]           o_side
);
    import fat_pkg::*;

    localparam int REM_W = ROOT_W + 2;

    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [RAD_W-1:0]  r_rad  [ROOT_W];
    logic [SIDE_W-1:0] r_side [ROOT_W];
    logic [REM_W-1:0]  s_rem  [ROOT_W];
    logic [ROOT_W-1:0] s_root [ROOT_W];
    logic [RAD_W-1:0]  s_rad  [ROOT_W];
    logic [SIDE_W-1:0] s_side [ROOT_W];
    logic [REM_W-1:0]  n_rem  [ROOT_W];
    logic [ROOT_W-1:0] n_root [ROOT_W];

    always_comb begin
        s_rem[0]  = '0;
        s_root[0] = '0;
        s_rad[0]  = i_rad;
        s_side[0] = i_side;
        for (int k = 1; k < ROOT_W; k++) begin
            s_rem[k]  = r_rem[k-1];
            s_root[k] = r_root[k-1];
            s_rad[k]  = r_rad[k-1];
            s_side[k] = r_side[k-1];
        end
    end

    always_comb begin
        logic [REM_W+1:0] cur;
        logic [REM_W+1:0] trial;
        for (int k = 0; k < ROOT_W; k++) begin
            cur   = {s_rem[k], s_rad[k][RAD_W-1 -: 2]};
            trial = (REM_W+2)'({s_root[k], 2'b01});
            if (cur >= trial) begin
                n_rem[k]  = REM_W'(cur - trial);
                n_root[k] = {s_root[k][ROOT_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = cur[REM_W-1:0];
                n_root[k] = {s_root[k][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < ROOT_W; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_rad[k]  <= {s_rad[k][RAD_W-3:0], 2'b00};
                r_side[k] <= s_side[k];
            end
        end
    end

    assign o_root  = r_root[ROOT_W-1];
    assign o_exact = (r_rem[ROOT_W-1] == '0);
    assign o_side  = r_side[ROOT_W-1];

endmodule

// ===== rtl/fat_lane.sv =====
// One two-circle estimate: linear coordinate, radicand, root and mirror.
module fat_lane #(
    parameter bit MIRROR = 1'b0
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [fat_pkg::DIST_W-1:0]  i_p,
    input  logic [fat_pkg::DIST_W-1:0]  i_q,
    input  logic [fat_pkg::EXT_W-1:0]   i_e,
    input  logic [fat_pkg::EXT_W-1:0]   i_m,
    output fat_pkg::t_lane_res          o_res
);
    import fat_pkg::*;

    logic [SQ_W-1:0]   r_p2, r_q2, r_e2;
    logic [DIST_W-1:0] r_p0;
    logic [NUM_W-1:0]  r_mag;
    t_pre_side         r_pre;
    logic [NUM_W-1:0]  div_quo;
    t_pre_side         div_side;
    logic [SQ_W-1:0]   r_tsq;
    t_pre_side         r_st;
    t_post_side        r_post;
    logic [RAD_W-1:0]  r_rad;
    t_post_side        r_post2;
    logic [ROOT_W-1:0] sq_root;
    logic              sq_exact;
    t_post_side        sq_side;
    t_lane_res         r_res;

    logic signed [NUM_W-1:0] n_num;
    logic [NUM_W-1:0]        n_quo;
    logic                    n_err;
    logic signed [OTH_W-1:0] n_oth;
    logic signed [OTH_W-1:0] m_s, s_s;

    always_comb begin
        n_num = $signed(NUM_W'(r_p2)) + $signed(NUM_W'(r_e2)) - $signed(NUM_W'(r_q2));
        n_quo = div_side.dz ? '0 : div_quo;
        n_err = (n_quo > NUM_W'(div_side.p));
        m_s   = $signed(OTH_W'(i_m));
        s_s   = $signed(OTH_W'(sq_root));
        if (!MIRROR) begin
            n_oth = s_s;
        end else if (sq_exact || !(m_s > s_s)) begin
            n_oth = m_s - s_s;
        end else begin
            n_oth = m_s - s_s - OTH_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p2      <= i_p * i_p;
            r_q2      <= i_q * i_q;
            r_e2      <= i_e * i_e;
            r_p0      <= i_p;
            r_pre.p   <= r_p0;
            r_pre.p2  <= r_p2;
            r_pre.neg <= n_num[NUM_W-1];
            r_pre.dz  <= (i_e == '0);
            r_mag     <= n_num[NUM_W-1] ? NUM_W'(-n_num) : NUM_W'(n_num);
            r_st      <= div_side;
            r_tsq     <= n_quo[DIST_W-1:0] * n_quo[DIST_W-1:0];
            r_post.lin <= div_side.neg ? -$signed(n_quo) : $signed(n_quo);
            r_post.err <= n_err;
            r_rad     <= r_post.err ? '0 : RAD_W'(r_st.p2 - r_tsq);
            r_post2   <= r_post;
            r_res.lin <= sq_side.lin;
            r_res.oth <= n_oth;
            r_res.err <= sq_side.err;
        end
    end

    fat_div #(.SIDE_W($bits(t_pre_side))) u_div (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_num  (r_mag),
        .i_den  ({i_e, 1'b0}),
        .i_side (r_pre),
        .o_quo  (div_quo),
        .o_side (div_side)
    );

    fat_sqrt #(.SIDE_W($bits(t_post_side))) u_sqrt (
        .i_clk   (i_clk),
        .i_en    (i_en),
        .i_rad   (r_rad),
        .i_side  (r_post2),
        .o_root  (sq_root),
        .o_exact (sq_exact),
        .o_side  (sq_side)
    );

    assign o_res = r_res;

endmodule

// ===== rtl/fat_merge.sv =====
// Sums the four estimates, divides by four toward zero and saturates.
module fat_merge (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  fat_pkg::t_lane_res                i_lane [fat_pkg::N_LANES],
    output logic signed [fat_pkg::POS_W-1:0]  o_pos_x,
    output logic signed [fat_pkg::POS_W-1:0]  o_pos_y,
    output logic                              o_err
);
    import fat_pkg::*;

    logic signed [SUM_W-1:0] r_sx, r_sy;
    logic                    r_err;
    logic signed [POS_W-1:0] r_x, r_y;
    logic                    r_err_o;

    function automatic logic signed [POS_W-1:0] avg_sat(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] q;
        q = (s + (s[SUM_W-1] ? SUM_W'(3) : SUM_W'(0))) >>> 2;
        if (q > $signed(SUM_W'(32767)))       avg_sat = 16'sh7FFF;
        else if (q < -$signed(SUM_W'(32768))) avg_sat = 16'sh8000;
        else                                  avg_sat = q[POS_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sx <= SUM_W'(i_lane[0].lin) + SUM_W'(i_lane[1].oth)
                  + SUM_W'(i_lane[2].lin) + SUM_W'(i_lane[3].oth);
            r_sy <= SUM_W'(i_lane[0].oth) + SUM_W'(i_lane[1].lin)
                  + SUM_W'(i_lane[2].oth) + SUM_W'(i_lane[3].lin);
            r_err   <= i_lane[0].err | i_lane[1].err | i_lane[2].err | i_lane[3].err;
            r_x     <= avg_sat(r_sx);
            r_y     <= avg_sat(r_sy);
            r_err_o <= r_err;
        end
    end

    assign o_pos_x = r_x;
    assign o_pos_y = r_y;
    assign o_err   = r_err_o;

endmodule

// ===== rtl/four_anchor_trilateration_core.sv =====
// Four-anchor trilateration core: four estimate lanes and an averaging merge.
// The pipeline has two product stages, a 32-stage divider, two radicand
// stages, a 15-stage root, a mirror stage and two averaging stages.
// Throughput is one transaction per cycle; the whole pipeline holds while the
// output register is full and stalled. Synchronous reset clears the stage valid
// bits and loads both room extents with 1000 at the next rising clock edge.
module four_anchor_trilateration_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_idx,
    input  logic [fat_pkg::EXT_W-1:0]          i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [fat_pkg::DIST_W-1:0]         i_dist_a,
    input  logic [fat_pkg::DIST_W-1:0]         i_dist_b,
    input  logic [fat_pkg::DIST_W-1:0]         i_dist_c,
    input  logic [fat_pkg::DIST_W-1:0]         i_dist_d,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [fat_pkg::POS_W-1:0]   o_pos_x,
    output logic signed [fat_pkg::POS_W-1:0]   o_pos_y,
    output logic                               o_geometry_error
);
    import fat_pkg::*;

    logic [EXT_W-1:0]    r_len, r_wid;
    logic [PIPE_LAT-1:0] r_vld;
    logic                adv;
    t_lane_res           lane_res [N_LANES];

    assign adv     = !(r_vld[PIPE_LAT-1] && i_stall);
    assign o_stall = !adv;
    assign o_valid = r_vld[PIPE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= EXT_RESET;
            r_wid <= EXT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_LENGTH: r_len <= i_cfg_data;
                CFG_WIDTH:  r_wid <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_valid};
        end
    end

    fat_lane #(.MIRROR(1'b0)) u_lane0 (
        .i_clk (i_clk), .i_en (adv),
        .i_p (i_dist_a), .i_q (i_dist_d), .i_e (r_len), .i_m (r_wid),
        .o_res (lane_res[0])
    );

    fat_lane #(.MIRROR(1'b0)) u_lane1 (
        .i_clk (i_clk), .i_en (adv),
        .i_p (i_dist_a), .i_q (i_dist_b), .i_e (r_wid), .i_m (r_len),
        .o_res (lane_res[1])
    );

    fat_lane #(.MIRROR(1'b1)) u_lane2 (
        .i_clk (i_clk), .i_en (adv),
        .i_p (i_dist_b), .i_q (i_dist_c), .i_e (r_len), .i_m (r_wid),
        .o_res (lane_res[2])
    );

    fat_lane #(.MIRROR(1'b1)) u_lane3 (
        .i_clk (i_clk), .i_en (adv),
        .i_p (i_dist_d), .i_q (i_dist_c), .i_e (r_wid), .i_m (r_len),
        .o_res (lane_res[3])
    );

    fat_merge u_merge (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_lane  (lane_res),
        .o_pos_x (o_pos_x),
        .o_pos_y (o_pos_y),
        .o_err   (o_geometry_error)
    );

endmodule
